>>> design/mbg_pkg.sv
// Shared types and constants for the maze backtracker generator.
`timescale 1ns / 1ps

package mbg_pkg;

  localparam int COORD_W   = 4;   // row or column in cell units
  localparam int DIR_W     = 2;
  localparam int COUNT_W   = 9;   // visited cell count, up to 256
  localparam int SIDE_W    = 5;   // side_in_use register width
  localparam int ENTRY_W   = 2 * COORD_W;  // stack entry: row high, column low
  localparam int SIDE_MIN  = 2;
  localparam int GRID_MAX  = 16;  // largest side the coordinate fields can address

  typedef enum logic [1:0] {
    EV_START  = 2'd0,
    EV_CARVE  = 2'd1,
    EV_REJECT = 2'd2,
    EV_IGNORE = 2'd3
  } event_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  localparam logic MODE_START = 1'b0;

endpackage

>>> design/maze_backtracker_generator.sv
// Top level of the maze backtracker generator: sequencer, visited-row memory, path stack.
`timescale 1ns / 1ps

//  channel   dir  beat payload
//  s_axis    in   tuser: mode; tdata: start_row, start_col, direction
//  m_axis    out  tuser: event_res; tdata: cell_row, cell_col, moved_toward,
//                 cells_visited, finished
//  cfg       in   cfg_we / cfg_wdata: side_in_use, taken on a rising edge with cfg_we high
//
//  A step beat runs through accept (neighbor rows read), current row read,
//  decide and write back. Each stack pop on a dead end adds a stack read,
//  a reload and a re-read of the rows. A start beat sweeps the visited memory,
//  one row a cycle, 2**clog2(side cap) rows, then emits. Reset is synchronous.
//  A waiting result holds the final state only until m_tready frees the slot.

module maze_backtracker_generator
  import mbg_pkg::*;
#(
  parameter int CELLS_PER_SIDE = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] start_row, [7:4] start_col, [9:8] direction
  input  logic        s_tuser,   // [0] mode
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] cell_row, [7:4] cell_col, [9:8] moved_toward,
                                 // [18:10] cells_visited, [19] finished
  output logic [1:0]  m_tuser,   // [1:0] event_res
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  // Largest side actually usable: bounded by the parameter and the 4-bit coordinates.
  localparam int SIDE_CAP = (CELLS_PER_SIDE > GRID_MAX) ? GRID_MAX :
                            ((CELLS_PER_SIDE < SIDE_MIN) ? SIDE_MIN : CELLS_PER_SIDE);
  localparam int ROW_AW   = $clog2(SIDE_CAP);
  localparam int ROWS     = 1 << ROW_AW;     // visited rows, also bits per row word
  localparam int STK_AW   = 2 * ROW_AW;
  localparam int STK_D    = 1 << STK_AW;

  localparam logic [SIDE_W-1:0] SIDE_CAP_V = SIDE_W'(SIDE_CAP);
  localparam logic [SIDE_W-1:0] SIDE_MIN_V = SIDE_W'(SIDE_MIN);

  typedef enum logic [2:0] {
    S_IDLE,   // wait for a beat; step reads rows r-1, r+1
    S_UD,     // capture up/down rows, read current row
    S_LR,     // decide: carve, reject or pop
    S_POP,    // stack entry arrives, becomes current cell
    S_RD,     // re-read neighbor rows after a pop
    S_CLR,    // sweep visited rows on start
    S_OUT     // emit start or ignore result
  } state_t;

  // ---------------- registers ----------------
  state_t                 state;
  logic [SIDE_W-1:0]      side_reg;      // side_in_use register
  logic [SIDE_W-1:0]      maze_side;     // side latched at start
  logic [COUNT_W-1:0]     side_sq;
  logic [COORD_W-1:0]     cur_row, cur_col;
  logic [COUNT_W-1:0]     total;
  logic [STK_AW-1:0]      stk_count;
  logic                   running, done;
  logic [DIR_W-1:0]       dir_q;
  event_t                 ev_q;
  logic [ROW_AW-1:0]      clr_idx;
  logic [ROWS-1:0]        w_up, w_dn;

  // output slot
  event_t                 o_event;
  logic [COORD_W-1:0]     o_row, o_col;
  logic [DIR_W-1:0]       o_moved;
  logic [COUNT_W-1:0]     o_total;
  logic                   o_done;

  // ---------------- memories ----------------
  logic [ROWS-1:0]        vis_mem [ROWS];
  logic [ENTRY_W-1:0]     stk_mem [STK_D];
  logic [ROWS-1:0]        vis_qa, vis_qb;
  logic [ENTRY_W-1:0]     stk_q;

  logic                   vis_we;
  logic [ROW_AW-1:0]      vis_wa, vis_ra, vis_rb;
  logic [ROWS-1:0]        vis_wd;
  logic                   stk_we;
  logic [STK_AW-1:0]      stk_wa, stk_ra;
  logic [ENTRY_W-1:0]     stk_wd;

  // ---------------- input decode ----------------
  logic [COORD_W-1:0]     in_row, in_col;
  logic [DIR_W-1:0]       in_dir;
  logic                   in_mode;
  logic                   accept;
  logic                   out_free;
  logic                   emit;

  assign in_row  = s_tdata[3:0];
  assign in_col  = s_tdata[7:4];
  assign in_dir  = s_tdata[9:8];
  assign in_mode = s_tuser;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Start-time side clamp and start cell saturation.
  logic [SIDE_W-1:0]      eff_side;
  logic [COORD_W-1:0]     st_row, st_col, side_m1;
  logic [COUNT_W-1:0]     eff_sq;

  always_comb begin
    if (side_reg < SIDE_MIN_V) begin
      eff_side = SIDE_MIN_V;
    end else if (side_reg > SIDE_CAP_V) begin
      eff_side = SIDE_CAP_V;
    end else begin
      eff_side = side_reg;
    end
    side_m1 = COORD_W'(eff_side - SIDE_W'(1));
    st_row  = ({1'b0, in_row} >= eff_side) ? side_m1 : in_row;
    st_col  = ({1'b0, in_col} >= eff_side) ? side_m1 : in_col;
    eff_sq  = COUNT_W'(eff_side * eff_side);
  end

  // ---------------- neighbor evaluation ----------------
  logic [ROW_AW-1:0]      r_ix, c_ix, c_lf, c_rt;
  logic [3:0]             open_mask;
  logic                   any_open, sel_open;
  logic [COORD_W-1:0]     nr, nc;
  logic [ROWS-1:0]        new_word;
  logic                   carve, pop, hit_all;

  always_comb begin
    r_ix = cur_row[ROW_AW-1:0];
    c_ix = cur_col[ROW_AW-1:0];
    c_lf = c_ix - ROW_AW'(1);
    c_rt = c_ix + ROW_AW'(1);
    open_mask[DIR_UP]    = (cur_row != '0) && !w_up[c_ix];
    open_mask[DIR_DOWN]  = (({1'b0, cur_row} + SIDE_W'(1)) < maze_side) && !w_dn[c_ix];
    open_mask[DIR_LEFT]  = (cur_col != '0) && !vis_qa[c_lf];
    open_mask[DIR_RIGHT] = (({1'b0, cur_col} + SIDE_W'(1)) < maze_side) && !vis_qa[c_rt];
    any_open = |open_mask;
    sel_open = open_mask[dir_q];
    nr = cur_row;
    nc = cur_col;
    new_word = vis_qa;
    case (dir_t'(dir_q))
      DIR_UP: begin
        nr = cur_row - COORD_W'(1);
        new_word = w_up;
      end
      DIR_DOWN: begin
        nr = cur_row + COORD_W'(1);
        new_word = w_dn;
      end
      DIR_LEFT:  nc = cur_col - COORD_W'(1);
      DIR_RIGHT: nc = cur_col + COORD_W'(1);
      default: ;
    endcase
    new_word = new_word | (ROWS'(1) << nc[ROW_AW-1:0]);
    carve   = (state == S_LR) && any_open && sel_open;
    pop     = (state == S_LR) && !any_open && (stk_count != '0);
    hit_all = ((total + COUNT_W'(1)) >= side_sq);
  end

  // a result goes into the output slot this cycle
  assign emit = out_free && (((state == S_LR) && !pop) || (state == S_OUT));

  // ---------------- memory port control ----------------
  always_comb begin
    // r-1 on the first read, current row once the up/down rows are in
    vis_ra = (state == S_UD || state == S_LR) ? r_ix : (r_ix - ROW_AW'(1));
    vis_rb = r_ix + ROW_AW'(1);
    vis_we = 1'b0;
    vis_wa = nr[ROW_AW-1:0];
    vis_wd = new_word;
    if (state == S_CLR) begin
      vis_we = 1'b1;
      vis_wa = clr_idx;
      vis_wd = (clr_idx == r_ix) ? (ROWS'(1) << c_ix) : '0;
    end else if (carve && out_free) begin
      vis_we = 1'b1;
    end
    stk_we = carve && out_free;
    stk_wa = stk_count;
    stk_wd = {cur_row, cur_col};
    stk_ra = stk_count - STK_AW'(1);
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_qa <= vis_mem[vis_ra];
    vis_qb <= vis_mem[vis_rb];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_ra];
  end

  // ---------------- sequencer and output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      side_reg  <= SIDE_W'(10);
      maze_side <= SIDE_MIN_V;
      side_sq   <= COUNT_W'(SIDE_MIN * SIDE_MIN);
      cur_row   <= '0;
      cur_col   <= '0;
      total     <= '0;
      stk_count <= '0;
      running   <= 1'b0;
      done      <= 1'b0;
      clr_idx   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        side_reg <= cfg_wdata;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            dir_q <= in_dir;
            if (in_mode == MODE_START) begin
              maze_side <= eff_side;
              side_sq   <= eff_sq;
              cur_row   <= st_row;
              cur_col   <= st_col;
              clr_idx   <= '0;
              state     <= S_CLR;
            end else if (!running) begin
              ev_q  <= EV_IGNORE;
              state <= S_OUT;
            end else begin
              state <= S_UD;
            end
          end
        end

        S_RD: state <= S_UD;

        S_UD: begin
          w_up  <= vis_qa;
          w_dn  <= vis_qb;
          state <= S_LR;
        end

        S_LR: begin
          if (pop) begin
            stk_count <= stk_count - STK_AW'(1);
            state     <= S_POP;
          end else if (out_free) begin
            if (carve) begin
              stk_count <= stk_count + STK_AW'(1);
              cur_row   <= nr;
              cur_col   <= nc;
              total     <= total + COUNT_W'(1);
              o_row     <= nr;
              o_col     <= nc;
              o_moved   <= dir_q;
              o_total   <= total + COUNT_W'(1);
              o_event   <= EV_CARVE;
              o_done    <= done | hit_all;
              if (hit_all) begin
                running <= 1'b0;
                done    <= 1'b1;
              end
            end else begin
              o_row   <= cur_row;
              o_col   <= cur_col;
              o_moved <= '0;
              o_total <= total;
              o_event <= EV_REJECT;
              o_done  <= done;
            end
            state <= S_IDLE;
          end
        end

        S_POP: begin
          cur_row <= stk_q[ENTRY_W-1:COORD_W];
          cur_col <= stk_q[COORD_W-1:0];
          state   <= S_RD;
        end

        S_CLR: begin
          clr_idx <= clr_idx + ROW_AW'(1);
          if (clr_idx == ROW_AW'(ROWS - 1)) begin
            total     <= COUNT_W'(1);
            stk_count <= '0;
            running   <= 1'b1;
            done      <= 1'b0;
            ev_q      <= EV_START;
            state     <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            o_event  <= ev_q;
            o_row    <= cur_row;
            o_col    <= cur_col;
            o_moved  <= '0;
            o_total  <= total;
            o_done   <= done;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'd0, o_done, o_total, o_moved, o_col, o_row};
  assign m_tuser = o_event;

endmodule

>>> sim/maze_backtracker_generator_test.sv
// Self-checking testbench for the maze backtracker generator: stream driver, monitor, maze predictor.
`timescale 1ns / 1ps

module maze_backtracker_generator_test;
  import mbg_pkg::*;

  localparam int CELLS = 16;
  localparam int SIDE_CAP = (CELLS < GRID_MAX) ? CELLS : GRID_MAX;
  localparam logic MODE_STEP = ~MODE_START;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off, backs up the input
  localparam int CYCLE_LIMIT = 600000;  // watchdog
  localparam int SETTLE = 12;           // idle cycles after the last result beat

  typedef struct packed {
    logic       mode;
    logic [3:0] row;
    logic [3:0] col;
    dir_t       dir;
  } maze_cmd_t;

  typedef struct packed {
    event_t     ev;
    logic [3:0] row;
    logic [3:0] col;
    dir_t       moved;
    logic [8:0] visited;
    logic       fin;
  } cell_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  maze_backtracker_generator #(.CELLS_PER_SIDE(CELLS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [3:0] start_row, [7:4] start_col, [9:8] direction
    .s_tuser  (s_tuser),   // [0] mode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [3:0] cell_row, [7:4] cell_col, [9:8] moved_toward,
                           // [18:10] cells_visited, [19] finished
    .m_tuser  (m_tuser),   // [1:0] event_res
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Maze predictor state: own copy of the grid, backtrack trail and register.
  // ---------------------------------------------------------------------------
  bit         seen_cell [256];
  logic [7:0] trail [256];       // row in high nibble, column in low nibble
  int         trail_depth = 0;
  logic [3:0] at_row = '0;
  logic [3:0] at_col = '0;
  int         cells_done = 0;
  bit         maze_live = 1'b0;
  bit         maze_complete = 1'b0;
  int         grid_side = SIDE_MIN;  // side latched at the last start
  logic [4:0] side_reg = 5'd10;      // register value after reset

  maze_cmd_t    maze_cmds[$];     // beats waiting for the driver
  cell_report_t cell_reports[$];  // predicted result beats, oldest first

  int cmds_queued = 0;
  int cmds_taken = 0;
  int bad_beats = 0;
  int cycles = 0;

  // idle styles: 0 none, 1 occasional gaps, 2 random gap drawn for every beat
  int          s_style = 1;
  int          m_style = 1;
  int unsigned s_gap = 0;
  int unsigned m_gap = 0;
  logic        s_took = 1'b0;
  logic        m_took = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_fired = 1'b0;
  int unsigned hold_left = 0;

  function automatic int unsigned draw_gap(input int style);
    if (style == 0) return 0;
    if (style == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    return $urandom_range(0, 19);
  endfunction

  // In-grid, unvisited neighbor in direction d; steps off the grid count as closed.
  function automatic bit open_dir(input logic [3:0] r, input logic [3:0] c, input dir_t d,
                                  output logic [3:0] nr, output logic [3:0] nc);
    int tr;
    int tc;
    tr = r;
    tc = c;
    nr = r;
    nc = c;
    case (d)
      DIR_UP: begin
        if (tr == 0) return 1'b0;
        tr = tr - 1;
      end
      DIR_DOWN: begin
        if (tr + 1 >= grid_side) return 1'b0;
        tr = tr + 1;
      end
      DIR_LEFT: begin
        if (tc == 0) return 1'b0;
        tc = tc - 1;
      end
      default: begin
        if (tc + 1 >= grid_side) return 1'b0;
        tc = tc + 1;
      end
    endcase
    if (seen_cell[tr * 16 + tc]) return 1'b0;
    nr = 4'(tr);
    nc = 4'(tc);
    return 1'b1;
  endfunction

  function automatic bit has_open(input logic [3:0] r, input logic [3:0] c);
    logic [3:0] nr;
    logic [3:0] nc;
    for (int d = 0; d < 4; d++) begin
      if (open_dir(r, c, dir_t'(d), nr, nc)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted command to the predicted maze and queue its result beat.
  task automatic advance_maze(input maze_cmd_t cmd);
    cell_report_t rep;
    logic [3:0]   nr;
    logic [3:0]   nc;
    logic [7:0]   top;
    int           side_eff;
    rep.moved = DIR_UP;
    if (cmd.mode == MODE_START) begin
      // side clamps to the legal range and is latched here
      side_eff = side_reg;
      if (side_eff < SIDE_MIN) side_eff = SIDE_MIN;
      if (side_eff > SIDE_CAP) side_eff = SIDE_CAP;
      grid_side = side_eff;
      foreach (seen_cell[i]) seen_cell[i] = 1'b0;
      // start coordinates outside the grid saturate to the last row or column
      at_row = (cmd.row >= grid_side) ? 4'(grid_side - 1) : cmd.row;
      at_col = (cmd.col >= grid_side) ? 4'(grid_side - 1) : cmd.col;
      seen_cell[at_row * 16 + at_col] = 1'b1;
      cells_done = 1;
      trail_depth = 0;
      maze_live = 1'b1;
      maze_complete = 1'b0;
      rep.ev = EV_START;
    end else if (!maze_live) begin
      rep.ev = EV_IGNORE;
    end else begin
      // dead end: unwind the trail until a cell with an open neighbor
      while (!has_open(at_row, at_col) && trail_depth > 0) begin
        trail_depth--;
        top = trail[trail_depth];
        at_row = top[7:4];
        at_col = top[3:0];
      end
      if (open_dir(at_row, at_col, cmd.dir, nr, nc)) begin
        if (trail_depth < 256) begin
          trail[trail_depth] = {at_row, at_col};
          trail_depth++;
        end
        at_row = nr;
        at_col = nc;
        seen_cell[nr * 16 + nc] = 1'b1;
        cells_done++;
        rep.moved = cmd.dir;
        rep.ev = EV_CARVE;
        if (cells_done >= grid_side * grid_side) begin
          maze_live = 1'b0;
          maze_complete = 1'b1;
        end
      end else begin
        rep.ev = EV_REJECT;
      end
    end
    rep.row = at_row;
    rep.col = at_col;
    rep.visited = 9'(cells_done);
    rep.fin = maze_complete;
    cell_reports.push_back(rep);
  endtask

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: watchdog, result check, input acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    cell_report_t want;
    cell_report_t got;
    maze_cmd_t    cmd;
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("maze_backtracker_generator: mismatch");
      $finish;
    end else begin
      s_took <= !rst && s_tvalid && s_tready;
      m_took <= !rst && m_tvalid && m_tready;
      if (!rst && m_tvalid && m_tready) begin
        got.ev = event_t'(m_tuser);
        got.row = m_tdata[3:0];
        got.col = m_tdata[7:4];
        got.moved = dir_t'(m_tdata[9:8]);
        got.visited = m_tdata[18:10];
        got.fin = m_tdata[19];
        if (cell_reports.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("unexpected result beat: ev=%0d row=%0d col=%0d", got.ev, got.row, got.col);
        end else begin
          want = cell_reports.pop_front();
          if (want !== got) begin
            bad_beats++;
            if (bad_beats <= 10) begin
              $display("result %0d: expected ev=%0d row=%0d col=%0d moved=%0d vis=%0d fin=%0d",
                       cmds_taken - cell_reports.size() - 1,
                       want.ev, want.row, want.col, want.moved, want.visited, want.fin);
              $display("  got ev=%0d row=%0d col=%0d moved=%0d vis=%0d fin=%0d",
                       got.ev, got.row, got.col, got.moved, got.visited, got.fin);
            end
          end
        end
      end
      if (!rst && s_tvalid && s_tready) begin
        cmd.mode = s_tuser;
        cmd.row = s_tdata[3:0];
        cmd.col = s_tdata[7:4];
        cmd.dir = dir_t'(s_tdata[9:8]);
        advance_maze(cmd);
        cmds_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents queued commands at the falling edge, holds until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : feed
    maze_cmd_t cmd;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (s_gap != 0) begin
        s_tvalid <= 1'b0;
        s_gap <= s_gap - 1;
      end else if (maze_cmds.size() != 0) begin
        cmd = maze_cmds.pop_front();
        s_tuser <= cmd.mode;
        s_tdata <= {6'b0, cmd.dir, cmd.col, cmd.row};
        s_tvalid <= 1'b1;
        s_gap <= draw_gap(s_style);  // wait before the following beat
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // One long hold-off of the result side, counted here.
  always @(negedge clk) begin : hold_off
    if (hold_req && !hold_fired) begin
      hold_left <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random wait before each result beat, plus the hold-off.
  always @(negedge clk) begin : drain_side
    int unsigned g;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      g = m_gap;
      if (m_took) g = draw_gap(m_style);
      m_tready <= (hold_left == 0 && g == 0);
      m_gap <= (g != 0) ? g - 1 : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_cmd(input logic mode, input logic [3:0] r, input logic [3:0] c,
                         input dir_t d);
    maze_cmd_t cmd;
    cmd.mode = mode;
    cmd.row = r;
    cmd.col = c;
    cmd.dir = d;
    maze_cmds.push_back(cmd);
    cmds_queued++;
  endtask

  task automatic start_at(input logic [3:0] r, input logic [3:0] c);
    add_cmd(MODE_START, r, c, dir_t'($urandom_range(0, 3)));
  endtask

  // step beats carry random, unused start coordinates
  task automatic step_dir(input dir_t d);
    add_cmd(MODE_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), d);
  endtask

  // Wait until every command is taken and every result is back, then let it settle.
  task automatic drain();
    while (cmds_taken != cmds_queued || cell_reports.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_side(input logic [4:0] v);
    drain();
    cfg_wdata = v;
    cfg_we = 1'b1;
    side_reg = v;
    @(negedge clk);
    cfg_we = 1'b0;
    @(posedge clk);
  endtask

  // Mostly complete mazes with random draws; some get abandoned by a new start.
  task automatic run_phase(input logic [4:0] side_val, input int budget, input bit press);
    int side_eff;
    int pushed;
    int steps;
    write_side(side_val);
    s_style = press ? 0 : $urandom_range(0, 2);
    m_style = $urandom_range(0, 2);
    side_eff = side_val;
    if (side_eff < SIDE_MIN) side_eff = SIDE_MIN;
    if (side_eff > SIDE_CAP) side_eff = SIDE_CAP;
    pushed = 0;
    while (pushed < budget) begin
      start_at(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      pushed++;
      if ($urandom_range(0, 4) == 0)
        steps = $urandom_range(1, side_eff * side_eff);
      else
        steps = side_eff * side_eff * 3 + $urandom_range(0, 6);
      for (int k = 0; k < steps && pushed < budget; k++) begin
        step_dir(dir_t'($urandom_range(0, 3)));
        pushed++;
      end
    end
    if (press) hold_req = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // reset side of 10, nothing running yet
    step_dir(DIR_UP);             // ignored, not running
    start_at(4'd15, 4'd15);       // saturates to the far corner
    step_dir(DIR_DOWN);           // border
    step_dir(DIR_RIGHT);          // border
    step_dir(DIR_UP);
    step_dir(DIR_LEFT);
    start_at(4'd0, 4'd0);         // abandons the running maze
    step_dir(DIR_UP);
    step_dir(DIR_LEFT);

    // smallest grid: full maze, then a step after completion
    write_side(5'd2);
    start_at(4'd0, 4'd0);
    step_dir(DIR_RIGHT);
    step_dir(DIR_DOWN);
    step_dir(DIR_LEFT);           // last cell, finished
    step_dir(DIR_UP);             // ignored, finished stays up

    // 3x3: walk into the corner dead end, next step backtracks one cell
    write_side(5'd3);
    start_at(4'd1, 4'd0);
    step_dir(DIR_RIGHT);
    step_dir(DIR_UP);
    step_dir(DIR_LEFT);           // (0,0) has no open neighbor now
    step_dir(DIR_RIGHT);          // pops to (0,1), carves to (0,2)
    step_dir(DIR_DOWN);
    start_at(4'd3, 4'd1);         // row saturates only

    // random part; the largest grid sees the long receiver hold-off
    run_phase(5'd4, 100, 1'b0);
    run_phase(5'd0, 80, 1'b0);    // clamps to 2
    run_phase(5'd16, 250, 1'b1);
    run_phase(5'd5, 100, 1'b0);
    run_phase(5'd31, 150, 1'b0);  // clamps to the cap
    run_phase(5'd1, 80, 1'b0);
    run_phase(5'd6, 100, 1'b0);
    run_phase(5'd17, 100, 1'b0);
    run_phase(5'd3, 80, 1'b0);
    run_phase(5'($urandom_range(2, 8)), 100, 1'b0);
    run_phase(5'd16, 120, 1'b0);
    run_phase(5'd8, 100, 1'b0);

    drain();
    if (bad_beats == 0 && cell_reports.size() == 0) begin
      $display("maze_backtracker_generator: match");
    end else begin
      $display("maze_backtracker_generator: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mbg_pkg.sv
design/maze_backtracker_generator.sv
sim/maze_backtracker_generator_test.sv
